>>> hw/rtl/alu_cf_pkg.sv
// alu_cf_pkg: operation codes and shared types for the carry-flag alu
// no dependencies; imported by alu_cf_exec, alu_with_carry_flag_core and testbench
`default_nettype none

package alu_cf_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned FUNC_W  = 5;
  localparam int unsigned COUNT_W = 6;

  localparam logic [FUNC_W-1:0] FUNC_AND  = 5'd0;
  localparam logic [FUNC_W-1:0] FUNC_OR   = 5'd1;
  localparam logic [FUNC_W-1:0] FUNC_XOR  = 5'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOT  = 5'd3;
  localparam logic [FUNC_W-1:0] FUNC_TEST = 5'd4;
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 5'd5;
  localparam logic [FUNC_W-1:0] FUNC_ADC  = 5'd6;
  localparam logic [FUNC_W-1:0] FUNC_SUB  = 5'd7;
  localparam logic [FUNC_W-1:0] FUNC_SBB  = 5'd8;
  localparam logic [FUNC_W-1:0] FUNC_SHL  = 5'd9;
  localparam logic [FUNC_W-1:0] FUNC_SHR  = 5'd10;
  localparam logic [FUNC_W-1:0] FUNC_DSHL = 5'd11;
  localparam logic [FUNC_W-1:0] FUNC_DSHR = 5'd12;
  localparam logic [FUNC_W-1:0] FUNC_MUL  = 5'd13;
  localparam logic [FUNC_W-1:0] FUNC_CLC  = 5'd14;
  localparam logic [FUNC_W-1:0] FUNC_STC  = 5'd15;
  localparam logic [FUNC_W-1:0] FUNC_CMC  = 5'd16;

  localparam logic [COUNT_W-1:0] MAX_SHIFT = 6'd32;

  typedef struct packed {
    logic carry;
    logic zero;
  } acf_flags_t;

endpackage

`default_nettype wire

>>> hw/rtl/alu_cf_exec.sv
// alu_cf_exec: combinational datapath for one alu operation, flags in and out
// depends on alu_cf_pkg
`default_nettype none

module alu_cf_exec
  import alu_cf_pkg::*;
(
  input  wire logic [FUNC_W-1:0]  func,
  input  wire logic [WORD_W-1:0]  operand_a,
  input  wire logic [WORD_W-1:0]  operand_b,
  input  wire logic [COUNT_W-1:0] shift_count,
  input  wire acf_flags_t         flags_in,
  output logic [WORD_W-1:0]       result_low,
  output logic [WORD_W-1:0]       result_high,
  output acf_flags_t              flags_out
);

  logic [COUNT_W-1:0]  cnt;
  logic                cnt_zero;
  logic                cin;
  logic [WORD_W:0]     sum;
  logic [WORD_W:0]     diff;
  logic [2*WORD_W-1:0] shl_a;
  logic [2*WORD_W-1:0] shr_a;
  logic [2*WORD_W-1:0] shl_b;
  logic [2*WORD_W-1:0] shr_b;
  logic [2*WORD_W-1:0] prod;

  // counts above one word saturate
  assign cnt      = (shift_count > MAX_SHIFT) ? MAX_SHIFT : shift_count;
  assign cnt_zero = (cnt == '0);

  // carry in only for adc and sbb
  assign cin  = ((func == FUNC_ADC) || (func == FUNC_SBB)) ? flags_in.carry : 1'b0;
  assign sum  = {1'b0, operand_a} + {1'b0, operand_b} + {{WORD_W{1'b0}}, cin};
  // bit 32 of the difference is the borrow
  assign diff = {1'b0, operand_a} - {1'b0, operand_b} - {{WORD_W{1'b0}}, cin};

  assign shl_a = {{WORD_W{1'b0}}, operand_a} << cnt;
  assign shr_a = {operand_a, {WORD_W{1'b0}}} >> cnt;
  assign shl_b = {{WORD_W{1'b0}}, operand_b} << cnt;
  assign shr_b = {operand_b, {WORD_W{1'b0}}} >> cnt;
  assign prod  = {{WORD_W{1'b0}}, operand_a} * {{WORD_W{1'b0}}, operand_b};

  always_comb begin
    result_low  = '0;
    result_high = '0;
    flags_out   = flags_in;
    case (func)
      FUNC_AND: result_low = operand_a & operand_b;
      FUNC_OR:  result_low = operand_a | operand_b;
      FUNC_XOR: result_low = operand_a ^ operand_b;
      FUNC_NOT: result_low = ~operand_a;
      FUNC_TEST: begin
        flags_out.zero = ((operand_a & operand_b) == '0);
      end
      FUNC_ADD, FUNC_ADC: begin
        result_low      = sum[WORD_W-1:0];
        flags_out.carry = sum[WORD_W];
      end
      FUNC_SUB, FUNC_SBB: begin
        result_low      = diff[WORD_W-1:0];
        flags_out.carry = diff[WORD_W];
      end
      FUNC_SHL: begin
        if (cnt_zero) begin
          result_low = operand_a;
        end else begin
          result_low      = shl_a[WORD_W-1:0];
          flags_out.carry = shl_a[WORD_W];
        end
      end
      FUNC_SHR: begin
        if (cnt_zero) begin
          result_low = operand_a;
        end else begin
          result_low      = shr_a[2*WORD_W-1:WORD_W];
          flags_out.carry = shr_a[WORD_W-1];
        end
      end
      FUNC_DSHL: begin
        if (cnt_zero) begin
          result_low  = operand_b;
          result_high = operand_a;
        end else begin
          result_low      = shl_b[WORD_W-1:0];
          result_high     = operand_a | shl_b[2*WORD_W-1:WORD_W];
          flags_out.carry = 1'b0;
        end
      end
      FUNC_DSHR: begin
        if (cnt_zero) begin
          result_low  = operand_b;
          result_high = operand_a;
        end else begin
          result_low      = shr_b[2*WORD_W-1:WORD_W];
          result_high     = operand_a | shr_b[WORD_W-1:0];
          flags_out.carry = 1'b0;
        end
      end
      FUNC_MUL: begin
        result_low  = prod[WORD_W-1:0];
        result_high = prod[2*WORD_W-1:WORD_W];
      end
      FUNC_CLC: flags_out.carry = 1'b0;
      FUNC_STC: flags_out.carry = 1'b1;
      FUNC_CMC: flags_out.carry = ~flags_in.carry;
      default: begin
        result_low  = '0;
        result_high = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/alu_with_carry_flag_core.sv
// alu_with_carry_flag_core: top level, input register, alu datapath, result register
// depends on alu_cf_pkg and alu_cf_exec
// The core takes one operation per cycle unless the result register is held full by a
// low out_ready, and returns one result per item, in order. An item waits in the input
// register, then the datapath (adder, shifters, one 32x32 multiplier) produces the
// result and the new carry and zero flags, which are written into the result register
// and the flag registers on the same edge, which also raises out_valid; with out_ready
// held high the core sustains one item per clock. The flags are kept in registers
// between items, so the carry seen by adc, sbb and cmc is the one left by the previous
// item. Reset clears both flags.
`default_nettype none

module alu_with_carry_flag_core
  import alu_cf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [FUNC_W-1:0]  in_func,
  input  wire logic [WORD_W-1:0]  in_operand_a,
  input  wire logic [WORD_W-1:0]  in_operand_b,
  input  wire logic [COUNT_W-1:0] in_shift_count,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [WORD_W-1:0]       out_result_low,
  output logic [WORD_W-1:0]       out_result_high,
  output logic                    out_carry_out,
  output logic                    out_zero_out
);

  logic               s1_valid_r;
  logic [FUNC_W-1:0]  s1_func_r;
  logic [WORD_W-1:0]  s1_a_r;
  logic [WORD_W-1:0]  s1_b_r;
  logic [COUNT_W-1:0] s1_cnt_r;

  acf_flags_t         flags_r;
  acf_flags_t         flags_nxt;

  logic               out_valid_r;
  logic [WORD_W-1:0]  res_low_r;
  logic [WORD_W-1:0]  res_high_r;
  logic               res_carry_r;
  logic               res_zero_r;

  logic [WORD_W-1:0]  exec_low;
  logic [WORD_W-1:0]  exec_high;
  logic               advance;

  // the input item moves on when the result register is free or being emptied
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  alu_cf_exec u_exec (
    .func        (s1_func_r),
    .operand_a   (s1_a_r),
    .operand_b   (s1_b_r),
    .shift_count (s1_cnt_r),
    .flags_in    (flags_r),
    .result_low  (exec_low),
    .result_high (exec_high),
    .flags_out   (flags_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        flags_r     <= flags_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_func_r <= in_func;
      s1_a_r    <= in_operand_a;
      s1_b_r    <= in_operand_b;
      s1_cnt_r  <= in_shift_count;
    end
    if (advance) begin
      res_low_r   <= exec_low;
      res_high_r  <= exec_high;
      res_carry_r <= flags_nxt.carry;
      res_zero_r  <= flags_nxt.zero;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_low  = res_low_r;
  assign out_result_high = res_high_r;
  assign out_carry_out   = res_carry_r;
  assign out_zero_out    = res_zero_r;

  // flags only move when an item passes into the result register
  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(flags_r))
    else $error("flags changed without an item advancing");

  // a waiting result always reports the live flags
  a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_carry_r == flags_r.carry) && (res_zero_r == flags_r.zero))
    else $error("result flags differ from flag registers");

  a_clc_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (s1_func_r == FUNC_CLC) |=> !flags_r.carry)
    else $error("clc did not clear carry");

  a_stc_sets: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (s1_func_r == FUNC_STC) |=> flags_r.carry)
    else $error("stc did not set carry");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// testbench: self-checking bench for alu_with_carry_flag_core
// depends on alu_cf_pkg and alu_with_carry_flag_core; predicts every result and its carry and zero flags in a class
`default_nettype none

module testbench
  import alu_cf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_ITEMS = 830;
  localparam int unsigned CALM_ITEMS = 120;
  localparam logic [FUNC_W-1:0] FUNC_UNKNOWN_LO = 5'd17;
  localparam logic [FUNC_W-1:0] FUNC_UNKNOWN_HI = 5'd31;

  typedef struct {
    logic [WORD_W-1:0] low;
    logic [WORD_W-1:0] high;
    logic              carry;
    logic              zero;
  } alu_result_t;

  class alu_result_scoreboard;
    logic        carry;
    logic        zero;
    alu_result_t awaited[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned carry_seen;
    int unsigned zero_seen;

    function new();
      carry = 1'b0;
      zero = 1'b0;
      errors = 0;
      checked = 0;
      carry_seen = 0;
      zero_seen = 0;
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    // works out the result of one accepted item and moves the flags on
    function void note_operation(logic [FUNC_W-1:0] func, logic [WORD_W-1:0] a,
                                 logic [WORD_W-1:0] b, logic [COUNT_W-1:0] count);
      logic [63:0]        t;
      logic [WORD_W-1:0]  lo;
      logic [WORD_W-1:0]  hi;
      logic [COUNT_W-1:0] n;
      alu_result_t        r;
      n = (count > MAX_SHIFT) ? MAX_SHIFT : count;
      lo = '0;
      hi = '0;
      case (func)
        FUNC_AND: lo = a & b;
        FUNC_OR: lo = a | b;
        FUNC_XOR: lo = a ^ b;
        FUNC_NOT: lo = ~a;
        FUNC_TEST: zero = ((a & b) == '0);
        FUNC_ADD: begin
          t = {32'b0, a} + {32'b0, b};
          carry = t[32];
          lo = t[31:0];
        end
        FUNC_ADC: begin
          t = {32'b0, a} + {32'b0, b} + {63'b0, carry};
          carry = t[32];
          lo = t[31:0];
        end
        FUNC_SUB: begin
          carry = (a < b);
          lo = a - b;
        end
        FUNC_SBB: begin
          t = {32'b0, b} + {63'b0, carry};
          carry = ({32'b0, a} < t);
          lo = a - t[31:0];
        end
        FUNC_SHL: begin
          if (n == 0) begin
            lo = a;
          end else begin
            t = {32'b0, a} << n;
            carry = t[32];
            lo = t[31:0];
          end
        end
        FUNC_SHR: begin
          if (n == 0) begin
            lo = a;
          end else begin
            t = {32'b0, a} >> (n - 1);
            carry = t[0];
            lo = a >> n;
          end
        end
        FUNC_DSHL: begin
          if (n == 0) begin
            lo = b;
            hi = a;
          end else begin
            t = {32'b0, b} << n;
            lo = t[31:0];
            hi = a | t[63:32];
            carry = 1'b0;
          end
        end
        FUNC_DSHR: begin
          if (n == 0) begin
            lo = b;
            hi = a;
          end else begin
            t = {b, 32'b0} >> n;
            lo = t[63:32];
            hi = a | t[31:0];
            carry = 1'b0;
          end
        end
        FUNC_MUL: begin
          t = {32'b0, a} * {32'b0, b};
          lo = t[31:0];
          hi = t[63:32];
        end
        FUNC_CLC: carry = 1'b0;
        FUNC_STC: carry = 1'b1;
        FUNC_CMC: carry = ~carry;
        default: ;
      endcase
      r.low = lo;
      r.high = hi;
      r.carry = carry;
      r.zero = zero;
      awaited.push_back(r);
    endfunction

    task report_mismatch(string field, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      $display("mismatch in %s at result %0d: got %h, want %h", field, checked, got, want);
      errors++;
    endtask

    task check_result(alu_result_t got);
      alu_result_t want;
      if (awaited.size() == 0) begin
        report_mismatch("unexpected item", got.low, '0);
      end else begin
        want = awaited.pop_front();
        if (got.low !== want.low) report_mismatch("result_low", got.low, want.low);
        if (got.high !== want.high) report_mismatch("result_high", got.high, want.high);
        if (got.carry !== want.carry)
          report_mismatch("carry_out", WORD_W'(got.carry), WORD_W'(want.carry));
        if (got.zero !== want.zero)
          report_mismatch("zero_out", WORD_W'(got.zero), WORD_W'(want.zero));
        if (want.carry) carry_seen++;
        if (want.zero) zero_seen++;
      end
      checked++;
    endtask
  endclass

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [FUNC_W-1:0]  in_func = '0;
  logic [WORD_W-1:0]  in_operand_a = '0;
  logic [WORD_W-1:0]  in_operand_b = '0;
  logic [COUNT_W-1:0] in_shift_count = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [WORD_W-1:0]  out_result_low;
  logic [WORD_W-1:0]  out_result_high;
  logic               out_carry_out;
  logic               out_zero_out;

  logic        calm = 1'b0;
  int unsigned cycles = 0;
  int unsigned sent = 0;
  alu_result_scoreboard board = new();

  alu_with_carry_flag_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_func        (in_func),
    .in_operand_a   (in_operand_a),
    .in_operand_b   (in_operand_b),
    .in_shift_count (in_shift_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result_low (out_result_low),
    .out_result_high(out_result_high),
    .out_carry_out  (out_carry_out),
    .out_zero_out   (out_zero_out)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // both handshakes are sampled on the edge, before any driver update lands
  always @(posedge clk) begin
    alu_result_t got;
    if (rst_n && in_valid && in_ready)
      board.note_operation(in_func, in_operand_a, in_operand_b, in_shift_count);
    if (rst_n && out_valid && out_ready) begin
      got.low = out_result_low;
      got.high = out_result_high;
      got.carry = out_carry_out;
      got.zero = out_zero_out;
      board.check_result(got);
    end
  end

  // receiver: bursts of stall and of readiness, steady once calm
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (calm || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  task send_item(logic [FUNC_W-1:0] func, logic [WORD_W-1:0] a, logic [WORD_W-1:0] b,
                 logic [COUNT_W-1:0] count);
    in_valid <= 1'b1;
    in_func <= func;
    in_operand_a <= a;
    in_operand_b <= b;
    in_shift_count <= count;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task hold_off(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  function logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h0000_0001;
      4: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function logic [COUNT_W-1:0] pick_count();
    if ($urandom_range(0, 9) == 0) return COUNT_W'($urandom_range(33, 63));
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? MAX_SHIFT : '0;
    return COUNT_W'($urandom_range(0, 32));
  endfunction

  task maybe_idle();
    if (!calm && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 11));
  endtask

  initial begin
    logic [FUNC_W-1:0] func;
    int unsigned       chain;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every operation, flag edge cases
    send_item(FUNC_AND, '1, 32'h0F0F_0F0F, 6'd0);
    send_item(FUNC_OR, 32'hF000_0000, 32'h0000_000F, 6'd0);
    send_item(FUNC_XOR, '1, 32'hAAAA_5555, 6'd0);
    send_item(FUNC_NOT, 32'h1234_5678, '1, 6'd0);
    send_item(FUNC_TEST, 32'hFFFF_0000, 32'h0000_FFFF, 6'd0);
    send_item(FUNC_TEST, 32'h8000_0000, '1, 6'd0);
    send_item(FUNC_ADD, '1, 32'h1, 6'd0);
    send_item(FUNC_ADC, '0, '0, 6'd0);
    send_item(FUNC_STC, '1, '1, 6'd63);
    send_item(FUNC_ADC, '1, '1, 6'd0);
    send_item(FUNC_SUB, '0, 32'h1, 6'd0);
    send_item(FUNC_SBB, 32'h5, 32'h5, 6'd0);
    send_item(FUNC_SHL, 32'h8000_0001, '0, 6'd1);
    send_item(FUNC_SHL, '1, '0, 6'd0);
    send_item(FUNC_SHR, 32'h1, '0, 6'd1);
    send_item(FUNC_SHR, 32'h8000_0000, '0, 6'd32);
    send_item(FUNC_SHL, 32'h1, '0, 6'd63);
    send_item(FUNC_DSHL, 32'h0000_0F00, 32'hAB00_00CD, 6'd8);
    send_item(FUNC_DSHR, 32'h00F0_0000, 32'hAB00_00CD, 6'd8);
    send_item(FUNC_DSHL, 32'h1234_0000, 32'h0000_5678, 6'd32);
    send_item(FUNC_DSHR, 32'h1234_0000, 32'h0000_5678, 6'd40);
    send_item(FUNC_DSHL, 32'hDEAD_BEEF, 32'hCAFE_F00D, 6'd0);
    send_item(FUNC_MUL, '1, '1, 6'd0);
    send_item(FUNC_CMC, '0, '0, 6'd0);
    send_item(FUNC_CLC, '0, '0, 6'd0);
    send_item(FUNC_UNKNOWN_HI, '1, '1, 6'd32);
    send_item(FUNC_UNKNOWN_LO, 32'h5555_AAAA, 32'hAAAA_5555, 6'd5);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain_results();
      if (i >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      maybe_idle();
      if ($urandom_range(0, 6) == 0) begin
        // multiword add or subtract: carry threads through the chain
        chain = $urandom_range(2, 4);
        send_item($urandom_range(0, 1) ? FUNC_ADD : FUNC_SUB, pick_word(), pick_word(),
                  pick_count());
        func = $urandom_range(0, 1) ? FUNC_ADC : FUNC_SBB;
        for (int k = 1; k < chain; k++) begin
          maybe_idle();
          send_item(func, pick_word(), pick_word(), pick_count());
        end
        i += chain - 1;
      end else begin
        if ($urandom_range(0, 19) == 0)
          func = FUNC_W'($urandom_range(FUNC_UNKNOWN_LO, FUNC_UNKNOWN_HI));
        else func = FUNC_W'($urandom_range(0, FUNC_CMC));
        send_item(func, pick_word(), pick_word(), pick_count());
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("sent %0d items over all seventeen operations and unknown codes", sent);
    $display("checked %0d results, %0d with carry set and %0d with zero set",
             board.checked, board.carry_seen, board.zero_seen);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
